// ===== rtl/core/ncdf_pkg.sv =====
// Shared constants, types and helper functions of the normal CDF evaluator.
`default_nettype none

package ncdf_pkg;

  // Default parameter values of the top level.
  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // Configuration register indexes.
  localparam logic [0:0] REG_MEAN  = 1'b0;
  localparam logic [0:0] REG_SIGMA = 1'b1;

  // Internal fixed point: 30 fraction bits.
  localparam int QB = 30;
  localparam logic [30:0] ONE_Q = 31'd1073741824;
  localparam logic signed [33:0] A1_Q = 34'sd273621191;
  localparam logic signed [33:0] A2_Q = -34'sd305476044;
  localparam logic signed [33:0] A3_Q = 34'sd1526231383;
  localparam logic signed [33:0] A4_Q = -34'sd1560310108;
  localparam logic signed [33:0] A5_Q = 34'sd1139675401;
  localparam logic [29:0] P_Q         = 30'd351748265;
  localparam logic [29:0] INV_SQRT2_Q = 30'd759250125;
  // ln2 in Q.30, scaled by 16 for the five-step quotient search.
  localparam logic [35:0] KDIV_D = 36'd744261118 << 4;
  localparam int EXP_TERMS = 11;
  localparam int QUO_BITS  = 33;

  // Stage offsets of the back half of the pipeline.
  localparam int ST_AZ_MUL  = 0;
  localparam int ST_AZ_RND  = 1;
  localparam int ST_DEN_MUL = 2;
  localparam int ST_SQ_MUL  = 3;
  localparam int ST_Z2      = 4;
  localparam int ST_RCP     = 5;
  localparam int RCP_STEPS  = 31;
  localparam int ST_POLY    = ST_RCP + RCP_STEPS;
  localparam int POLY_STEPS = 5;
  localparam int ST_KDIV    = ST_POLY + 2 * POLY_STEPS;
  localparam int KDIV_STEPS = 5;
  localparam int ST_ER      = ST_KDIV + KDIV_STEPS;
  localparam int ST_EXP     = ST_ER + 1;
  localparam int ST_ESH     = ST_EXP + 4 * EXP_TERMS;
  localparam int ST_YMUL    = ST_ESH + 1;
  localparam int ST_Y       = ST_YMUL + 1;
  localparam int NB         = ST_Y + 1;

  // Working set of one sample in the back half of the pipeline.
  typedef struct packed {
    logic              neg;
    logic              big;
    logic              pneg;
    logic [32:0]       az;
    logic [30:0]       azs;
    logic [31:0]       den;
    logic [29:0]       low;
    logic [32:0]       rr;
    logic [30:0]       t;
    logic signed [33:0] poly;
    logic [34:0]       z2;
    logic [35:0]       kr;
    logic [4:0]        k;
    logic [29:0]       er;
    logic [30:0]       acc;
    logic [30:0]       v;
    logic [63:0]       prod;
  } item_t;

  function automatic logic [63:0] mul_u(input logic [63:0] a, input logic [63:0] b);
    return a * b;
  endfunction

  // Round a Q.60 product to Q.30, half away from zero on the magnitude.
  function automatic logic [33:0] rnd30(input logic [63:0] p);
    logic [64:0] s;
    s = {1'b0, p} + 65'd536870912;
    return s[63:30];
  endfunction

  // Addend after each Horner step of the polynomial in t.
  function automatic logic signed [33:0] poly_add(input int m);
    case (m)
      0:       return A4_Q;
      1:       return A3_Q;
      2:       return A2_Q;
      3:       return A1_Q;
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/normal_cdf_erf_approx.sv =====
// Top level of the pipelined normal CDF and erf evaluator.
`default_nettype none

// Usage notes.
// Samples come in on the command channel: a beat is taken at each rising edge
// where start is high and busy is low. busy is high during reset and in the
// first cycle after it, so one sample can be accepted in every cycle.
// Each result beat appears on out_erf_value and out_cdf_value for exactly one
// cycle, flagged by out_valid, from the output register behind the back half.
// Results leave in the order the samples came in. The receiver cannot hold
// results off, and the pipeline never stalls, so nothing waits anywhere.
// The latency is set by the 33-step restoring divider for (x - mean) / sigma
// and the 31-step reciprocal t = 1 / (1 + p|z|), each taking one stage per
// step, and by the eleven-term Horner series for exp(-z*z), which takes four
// stages per term.
// The mean and sigma registers are written through the cfg_ port and are read
// by stage A and the divider, so they must only change while no sample is
// inside the pipeline. Reset (synchronous, active low) clears all valid bits,
// sets the mean to zero and sigma to one; samples in flight are dropped.

module normal_cdf_erf_approx #(
  parameter int FRAC_BITS  = ncdf_pkg::DEF_FRAC_BITS,
  parameter int DATA_WIDTH = ncdf_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] in_x_value,
  output logic                              out_valid,
  output logic signed [FRAC_BITS+1:0]       out_erf_value,
  output logic [FRAC_BITS:0]                out_cdf_value,
  input  wire logic                         cfg_we,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  // Remainder width of the ratio divider: holds 8 * sigma and the magnitude.
  localparam int RW = DW + 3;
  localparam int QN = ncdf_pkg::QUO_BITS;
  localparam int NB = ncdf_pkg::NB;
  localparam logic [DW-2:0] SIG_RESET = (DW-1)'(1) << FB;

  // Configuration registers.
  logic [DW-1:0] mean_r;
  logic [DW-2:0] sig_r;
  logic          busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      sig_r  <= SIG_RESET;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          ncdf_pkg::REG_MEAN:  mean_r <= cfg_data;
          ncdf_pkg::REG_SIGMA: sig_r  <= cfg_data[DW-2:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  logic accept;
  assign accept = start && !busy_r;

  // Stage A: signed difference and its magnitude.
  logic signed [DW:0] diff_nxt;
  logic               neg_nxt;
  logic [DW:0]        mag_nxt;

  assign diff_nxt = $signed({in_x_value[DW-1], in_x_value}) - $signed({mean_r[DW-1], mean_r});
  assign neg_nxt  = diff_nxt[DW];
  assign mag_nxt  = neg_nxt ? (~diff_nxt + 1'b1) : diff_nxt;

  logic        a_v_r;
  logic        a_neg_r;
  logic [DW:0] a_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_neg_r <= neg_nxt;
    a_mag_r <= mag_nxt;
  end

  // Stage B and the ratio divider. Quotient bits come out MSB first against
  // a fixed divisor of 4 * sigma while the remainder doubles each step, which
  // gives three integer bits and thirty fraction bits of |d| / sigma.
  logic [RW-1:0] six_sig;
  logic [RW-1:0] div_d;

  assign six_sig = RW'({sig_r, 2'b00}) + RW'({sig_r, 1'b0});
  assign div_d   = RW'({sig_r, 2'b00});

  logic          dv_v_r    [0:QN];
  logic          dv_neg_r  [0:QN];
  logic          dv_big_r  [0:QN];
  logic          dv_zero_r [0:QN];
  logic [RW-1:0] dv_rem_r  [0:QN];
  logic [QN-1:0] dv_quo_r  [0:QN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_neg_r[0]  <= a_neg_r;
    dv_big_r[0]  <= (a_mag_r != '0) && (RW'(a_mag_r) >= six_sig);
    dv_zero_r[0] <= (a_mag_r == '0);
    dv_rem_r[0]  <= RW'(a_mag_r);
    dv_quo_r[0]  <= '0;
  end

  for (genvar i = 0; i < QN; i++) begin : g_div
    logic          bit_nxt;
    logic [RW-1:0] sub_nxt;

    assign bit_nxt = dv_rem_r[i] >= div_d;
    assign sub_nxt = bit_nxt ? (dv_rem_r[i] - div_d) : dv_rem_r[i];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i+1] <= 1'b0;
      end else begin
        dv_v_r[i+1] <= dv_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      dv_neg_r[i+1]  <= dv_neg_r[i];
      dv_big_r[i+1]  <= dv_big_r[i];
      dv_zero_r[i+1] <= dv_zero_r[i];
      dv_rem_r[i+1]  <= {sub_nxt[RW-2:0], 1'b0};
      dv_quo_r[i+1]  <= {dv_quo_r[i][QN-2:0], bit_nxt};
    end
  end

  // Back half: fixed Q.30 arithmetic, independent of the port widths.
  ncdf_pkg::item_t bk_in;

  always_comb begin
    bk_in     = '0;
    bk_in.neg = dv_neg_r[QN];
    bk_in.big = dv_big_r[QN];
    // A zero difference replaces the quotient with zero; sigma may be zero then.
    bk_in.az  = dv_zero_r[QN] ? '0 : dv_quo_r[QN];
  end

  ncdf_pkg::item_t bk_src [0:NB-1];
  ncdf_pkg::item_t bk_nxt [0:NB-1];
  ncdf_pkg::item_t bk_r   [0:NB-1];
  logic            bk_vs  [0:NB-1];
  logic            bk_v_r [0:NB-1];

  for (genvar s = 0; s < NB; s++) begin : g_bk
    if (s == 0) begin : g_first
      assign bk_src[s] = bk_in;
      assign bk_vs[s]  = dv_v_r[QN];
    end else begin : g_next
      assign bk_src[s] = bk_r[s-1];
      assign bk_vs[s]  = bk_v_r[s-1];
    end

    if (s == ncdf_pkg::ST_AZ_MUL) begin : g_azmul
      always_comb begin
        bk_nxt[s]      = bk_src[s];
        bk_nxt[s].prod = ncdf_pkg::mul_u(64'(bk_src[s].az), 64'(ncdf_pkg::INV_SQRT2_Q));
      end
    end else if (s == ncdf_pkg::ST_AZ_RND) begin : g_azrnd
      always_comb begin
        logic [33:0] r;
        r            = ncdf_pkg::rnd30(bk_src[s].prod);
        bk_nxt[s]    = bk_src[s];
        bk_nxt[s].az = r[32:0];
      end
    end else if (s == ncdf_pkg::ST_DEN_MUL) begin : g_denmul
      always_comb begin
        logic [33:0] sum;
        sum             = {1'b0, bk_src[s].az} + 34'd2;
        bk_nxt[s]       = bk_src[s];
        bk_nxt[s].prod  = ncdf_pkg::mul_u(64'(bk_src[s].az), 64'(ncdf_pkg::P_Q));
        bk_nxt[s].azs   = sum[32:2];
      end
    end else if (s == ncdf_pkg::ST_SQ_MUL) begin : g_sqmul
      always_comb begin
        logic [33:0] r;
        r              = ncdf_pkg::rnd30(bk_src[s].prod);
        bk_nxt[s]      = bk_src[s];
        bk_nxt[s].den  = 32'(ncdf_pkg::ONE_Q) + r[31:0];
        bk_nxt[s].prod = ncdf_pkg::mul_u(64'(bk_src[s].azs), 64'(bk_src[s].azs));
      end
    end else if (s == ncdf_pkg::ST_Z2) begin : g_z2
      always_comb begin
        logic [64:0] sum;
        sum            = {1'b0, bk_src[s].prod} + 65'd33554432;
        bk_nxt[s]      = bk_src[s];
        bk_nxt[s].z2   = sum[60:26];
        bk_nxt[s].kr   = {1'b0, sum[60:26]};
        bk_nxt[s].k    = '0;
        // Numerator 2^60 + den/2: top part and the low bits shifted in later.
        bk_nxt[s].rr   = 33'(ncdf_pkg::ONE_Q) + 33'(bk_src[s].den[31]);
        bk_nxt[s].low  = bk_src[s].den[30:1];
        bk_nxt[s].t    = '0;
        bk_nxt[s].poly = ncdf_pkg::A5_Q;
      end
    end else if (s < ncdf_pkg::ST_POLY) begin : g_rcp
      localparam int J = s - ncdf_pkg::ST_RCP;
      localparam int LI = (J < 30) ? (29 - J) : 0;
      always_comb begin
        logic        b;
        logic [32:0] rs;
        b            = bk_src[s].rr >= {1'b0, bk_src[s].den};
        rs           = b ? (bk_src[s].rr - {1'b0, bk_src[s].den}) : bk_src[s].rr;
        bk_nxt[s]    = bk_src[s];
        bk_nxt[s].t  = {bk_src[s].t[29:0], b};
        if (J < 30) begin
          bk_nxt[s].rr = {rs[31:0], bk_src[s].low[LI]};
        end else begin
          bk_nxt[s].rr = rs;
        end
      end
    end else if (s < ncdf_pkg::ST_KDIV) begin : g_poly
      localparam int M  = (s - ncdf_pkg::ST_POLY) / 2;
      localparam int PH = (s - ncdf_pkg::ST_POLY) % 2;
      if (PH == 0) begin : g_mul
        always_comb begin
          logic        pn;
          logic [33:0] mag;
          pn             = bk_src[s].poly[33];
          mag            = pn ? (~bk_src[s].poly + 1'b1) : bk_src[s].poly;
          bk_nxt[s]      = bk_src[s];
          bk_nxt[s].pneg = pn;
          bk_nxt[s].prod = ncdf_pkg::mul_u(64'(mag), 64'(bk_src[s].t));
        end
      end else begin : g_add
        always_comb begin
          logic [33:0]        r;
          logic signed [34:0] sv;
          logic signed [34:0] sum;
          r    = ncdf_pkg::rnd30(bk_src[s].prod);
          sv   = bk_src[s].pneg ? -$signed({1'b0, r}) : $signed({1'b0, r});
          sum  = sv + 35'(ncdf_pkg::poly_add(M));
          bk_nxt[s]      = bk_src[s];
          bk_nxt[s].poly = sum[33:0];
        end
      end
    end else if (s < ncdf_pkg::ST_ER) begin : g_kdiv
      always_comb begin
        logic        b;
        logic [35:0] ks;
        b            = bk_src[s].kr >= ncdf_pkg::KDIV_D;
        ks           = b ? (bk_src[s].kr - ncdf_pkg::KDIV_D) : bk_src[s].kr;
        bk_nxt[s]    = bk_src[s];
        bk_nxt[s].kr = {ks[34:0], 1'b0};
        bk_nxt[s].k  = {bk_src[s].k[3:0], b};
      end
    end else if (s == ncdf_pkg::ST_ER) begin : g_er
      always_comb begin
        bk_nxt[s]     = bk_src[s];
        bk_nxt[s].er  = bk_src[s].kr[34:5];
        bk_nxt[s].acc = ncdf_pkg::ONE_Q;
      end
    end else if (s < ncdf_pkg::ST_ESH) begin : g_exp
      localparam int TI = (s - ncdf_pkg::ST_EXP) / 4;
      localparam int PH = (s - ncdf_pkg::ST_EXP) % 4;
      localparam int N  = ncdf_pkg::EXP_TERMS - TI;
      // Reciprocal of the term index; the floor makes the quotient at most
      // one short, which the last phase corrects.
      localparam logic [32:0] RM = 33'((64'd1 << 32) / N);
      if (PH == 0) begin : g_pmul
        always_comb begin
          bk_nxt[s]      = bk_src[s];
          bk_nxt[s].prod = ncdf_pkg::mul_u(64'(bk_src[s].er), 64'(bk_src[s].acc));
        end
      end else if (PH == 1) begin : g_prnd
        always_comb begin
          logic [33:0] r;
          r           = ncdf_pkg::rnd30(bk_src[s].prod);
          bk_nxt[s]   = bk_src[s];
          bk_nxt[s].v = r[30:0];
        end
      end else if (PH == 2) begin : g_rmul
        always_comb begin
          bk_nxt[s]      = bk_src[s];
          bk_nxt[s].prod = ncdf_pkg::mul_u(64'(bk_src[s].v), 64'(RM));
        end
      end else begin : g_corr
        always_comb begin
          logic [30:0] q0;
          logic [63:0] qn;
          logic [35:0] rm;
          logic        c;
          q0  = bk_src[s].prod[62:32];
          qn  = ncdf_pkg::mul_u(64'(q0), 64'(N));
          rm  = 36'(bk_src[s].v) - qn[35:0];
          c   = rm >= 36'(N);
          bk_nxt[s]     = bk_src[s];
          bk_nxt[s].acc = ncdf_pkg::ONE_Q - (q0 + 31'(c));
        end
      end
    end else if (s == ncdf_pkg::ST_ESH) begin : g_esh
      always_comb begin
        logic [31:0] sh;
        sh        = ({1'b0, bk_src[s].acc} + (32'd1 << (bk_src[s].k - 5'd1))) >> bk_src[s].k;
        bk_nxt[s] = bk_src[s];
        if (bk_src[s].k != '0) begin
          bk_nxt[s].acc = sh[30:0];
        end
      end
    end else if (s == ncdf_pkg::ST_YMUL) begin : g_ymul
      always_comb begin
        logic        pn;
        logic [33:0] mag;
        pn             = bk_src[s].poly[33];
        mag            = pn ? (~bk_src[s].poly + 1'b1) : bk_src[s].poly;
        bk_nxt[s]      = bk_src[s];
        bk_nxt[s].pneg = pn;
        bk_nxt[s].prod = ncdf_pkg::mul_u(64'(mag), 64'(bk_src[s].acc));
      end
    end else begin : g_y
      always_comb begin
        logic [33:0]        r;
        logic signed [35:0] sv;
        logic signed [35:0] y;
        r  = ncdf_pkg::rnd30(bk_src[s].prod);
        sv = bk_src[s].pneg ? -$signed({2'b0, r}) : $signed({2'b0, r});
        y  = $signed(36'(ncdf_pkg::ONE_Q)) - sv;
        bk_nxt[s] = bk_src[s];
        if (bk_src[s].big || (y > $signed(36'(ncdf_pkg::ONE_Q)))) begin
          bk_nxt[s].acc = ncdf_pkg::ONE_Q;
        end else if (y < 0) begin
          bk_nxt[s].acc = '0;
        end else begin
          bk_nxt[s].acc = y[30:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        bk_v_r[s] <= 1'b0;
      end else begin
        bk_v_r[s] <= bk_vs[s];
      end
    end

    always_ff @(posedge clk) begin
      bk_r[s] <= bk_nxt[s];
    end
  end

  // Output stage: round from Q.30 to the port format and saturate.
  localparam logic [31:0] ERF_HALF = 32'd1 << (ncdf_pkg::QB - 1 - FB);
  localparam logic [31:0] CDF_HALF = 32'd1 << (ncdf_pkg::QB - FB);
  localparam logic [32:0] UNIT     = 33'd1 << FB;

  logic [30:0]      y_fin;
  logic             neg_fin;
  logic [31:0]      m_sum;
  logic [32:0]      m_val;
  logic [32:0]      m_sat;
  logic [31:0]      c_val;
  logic [32:0]      cdf_val;
  logic [32:0]      cdf_sat;
  logic [FB+1:0]    erf_nxt;
  logic [FB:0]      cdf_nxt;

  assign y_fin   = bk_r[NB-1].acc;
  assign neg_fin = bk_r[NB-1].neg;
  assign m_sum   = {1'b0, y_fin} + ERF_HALF;
  assign m_val   = 33'(m_sum >> (ncdf_pkg::QB - FB));
  assign m_sat   = (m_val > UNIT) ? UNIT : m_val;
  assign c_val   = neg_fin ? (32'(ncdf_pkg::ONE_Q) - 32'(y_fin))
                           : (32'(ncdf_pkg::ONE_Q) + 32'(y_fin));
  assign cdf_val = ({1'b0, c_val} + 33'(CDF_HALF)) >> (ncdf_pkg::QB + 1 - FB);
  assign cdf_sat = (cdf_val > UNIT) ? UNIT : cdf_val;
  assign erf_nxt = neg_fin ? (~m_sat[FB+1:0] + 1'b1) : m_sat[FB+1:0];
  assign cdf_nxt = cdf_sat[FB:0];

  logic                 out_valid_r;
  logic signed [FB+1:0] out_erf_r;
  logic [FB:0]          out_cdf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= bk_v_r[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    out_erf_r <= erf_nxt;
    out_cdf_r <= cdf_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_erf_value = out_erf_r;
  assign out_cdf_value = out_cdf_r;

endmodule

`default_nettype wire

// ===== rtl/core/ncdf_checker.sv =====
// Port-level assertions for the normal CDF evaluator and their bind.
`default_nettype none

module ncdf_checker #(
  parameter int FRAC_BITS = ncdf_pkg::DEF_FRAC_BITS
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic signed [FRAC_BITS+1:0] out_erf_value,
  input wire logic [FRAC_BITS:0]          out_cdf_value
);

  localparam int UNIT = 2 ** FRAC_BITS;
  localparam int HALF = 2 ** (FRAC_BITS - 1);

  // Reset drops every beat in flight.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_erf_value) <= UNIT) && ($signed(out_erf_value) >= -UNIT)
                  && (out_cdf_value <= UNIT))
    else $error("result beyond plus or minus one");

  // A zero erf must come with a CDF of exactly one half.
  a_zero_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_erf_value == '0) |-> (out_cdf_value == HALF))
    else $error("erf zero without CDF one half");

  a_neg_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($signed(out_erf_value) < 0) |-> (out_cdf_value <= HALF))
    else $error("negative erf with CDF above one half");

  a_pos_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($signed(out_erf_value) > 0) |-> (out_cdf_value >= HALF))
    else $error("positive erf with CDF below one half");

endmodule

bind normal_cdf_erf_approx ncdf_checker #(.FRAC_BITS(FRAC_BITS)) u_ncdf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_erf_value (out_erf_value),
  .out_cdf_value (out_cdf_value)
);

`default_nettype wire
